@@ rtl/cpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cpfs_pkg - shared types and constants for the particle field step core
// Payload structs, config register codes, microcode word format and the
// fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
package cpfs_pkg;

    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_QM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX   = 3'd4;

    // microprogram entry points past the advance sequence
    localparam logic [STEP_W-1:0] A_CHK  = 5'd25;
    localparam logic [STEP_W-1:0] A_HOLD = 5'd26;
    localparam logic [STEP_W-1:0] A_LOAD = 5'd27;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_vx;
        logic signed [31:0] load_vy;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic               out_of_bounds;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] qm;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic [30:0]        dt;
        logic [30:0]        box;
    } cfg_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_BR_LOAD,
        SEQ_BR_HALT,
        SEQ_DONE
    } seq_t;

    typedef enum logic [1:0] {
        AOP_PASS,
        AOP_ADD,
        AOP_SUB
    } aop_t;

    // operand sources and writeback targets
    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_DT,
        SRC_QM,
        SRC_ALPHA,
        SRC_BETA,
        SRC_PX,
        SRC_PY,
        SRC_VX,
        SRC_VY,
        SRC_K,
        SRC_F0,
        SRC_G,
        SRC_SA,
        SRC_SB,
        SRC_VXR,
        SRC_VYR,
        SRC_F1,
        SRC_SX,
        SRC_SY
    } src_t;

    typedef struct packed {
        seq_t              seq;
        logic [STEP_W-1:0] target;
        src_t              a;
        src_t              b;
        logic              sh17;
        aop_t              aop;
        src_t              c;
        logic              wb;
        src_t              dst;
        logic              ld;
        logic              chk;
    } ucode_t;

    // control that follows a product down the datapath
    typedef struct packed {
        logic wb;
        src_t dst;
        aop_t aop;
        src_t c;
        logic sh17;
    } wbctl_t;

    localparam ucode_t UC_NOP = '{
        seq: SEQ_NEXT, target: '0, a: SRC_ZERO, b: SRC_ZERO, sh17: 1'b0,
        aop: AOP_PASS, c: SRC_ZERO, wb: 1'b0, dst: SRC_ZERO, ld: 1'b0, chk: 1'b0
    };

    localparam logic signed [64:0] RND16  = 65'sd32768;
    localparam logic signed [64:0] RND17  = 65'sd65536;
    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

    // round to nearest, ties up (floor after adding half), then saturate
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p,
                                                     input logic sh17);
        logic signed [64:0] r;
        logic signed [64:0] q;
        r = 65'(p) + (sh17 ? RND17 : RND16);
        q = sh17 ? (r >>> 17) : (r >>> 16);
        if (q > SAT_HI)
            return 32'sh7FFF_FFFF;
        else if (q < SAT_LO)
            return 32'sh8000_0000;
        else
            return q[31:0];
    endfunction

    function automatic logic signed [31:0] addsub_sat(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic sub);
        logic signed [32:0] s;
        s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            return s[31:0];
    endfunction

endpackage

@@ rtl/cpfs_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// cpfs_ucode_rom - microprogram for one integration step
// Each arithmetic word issues one multiply and names where its rounded product goes.
// A product is registered, rounded and added before write back, so dependent words are spaced.
// ----------------------------------------------------------------------------
module cpfs_ucode_rom
    import cpfs_pkg::*;
(
    input  logic [STEP_W-1:0] addr,
    output ucode_t            word
);

    function automatic ucode_t uop(input src_t a, input src_t b, input logic sh17,
                                   input aop_t aop, input src_t c, input src_t dst);
        ucode_t w;
        w      = UC_NOP;
        w.a    = a;
        w.b    = b;
        w.sh17 = sh17;
        w.aop  = aop;
        w.c    = c;
        w.wb   = 1'b1;
        w.dst  = dst;
        return w;
    endfunction

    function automatic ucode_t uctl(input seq_t seq, input logic [STEP_W-1:0] target,
                                    input logic ld, input logic chk);
        ucode_t w;
        w        = UC_NOP;
        w.seq    = seq;
        w.target = target;
        w.ld     = ld;
        w.chk    = chk;
        return w;
    endfunction

    always_comb
    begin
        case (addr)
            5'd0:  word = uctl(SEQ_BR_LOAD, A_LOAD, 1'b0, 1'b0);
            5'd1:  word = uctl(SEQ_BR_HALT, A_HOLD, 1'b0, 1'b0);
            // k = dt*qm, f0 = alpha + beta*x0
            5'd2:  word = uop(SRC_DT,   SRC_QM,   1'b0, AOP_PASS, SRC_ZERO,  SRC_K);
            5'd3:  word = uop(SRC_BETA, SRC_PX,   1'b0, AOP_ADD,  SRC_ALPHA, SRC_F0);
            5'd6:  word = uop(SRC_K,    SRC_F0,   1'b0, AOP_PASS, SRC_ZERO,  SRC_G);
            5'd7:  word = uop(SRC_F0,   SRC_VY,   1'b0, AOP_PASS, SRC_ZERO,  SRC_SA);
            5'd8:  word = uop(SRC_F0,   SRC_VX,   1'b0, AOP_PASS, SRC_ZERO,  SRC_SB);
            // predicted velocity
            5'd9:  word = uop(SRC_VY,   SRC_G,    1'b0, AOP_ADD,  SRC_VX,    SRC_VXR);
            5'd10: word = uop(SRC_VX,   SRC_G,    1'b0, AOP_SUB,  SRC_VY,    SRC_VYR);
            // new position goes straight into the state
            5'd12: word = uop(SRC_DT,   SRC_VXR,  1'b0, AOP_ADD,  SRC_PX,    SRC_PX);
            5'd13: word = uop(SRC_DT,   SRC_VYR,  1'b0, AOP_ADD,  SRC_PY,    SRC_PY);
            5'd15: word = uop(SRC_BETA, SRC_PX,   1'b0, AOP_ADD,  SRC_ALPHA, SRC_F1);
            5'd18: word = uop(SRC_F1,   SRC_VYR,  1'b0, AOP_ADD,  SRC_SA,    SRC_SX);
            5'd19: word = uop(SRC_F1,   SRC_VXR,  1'b0, AOP_ADD,  SRC_SB,    SRC_SY);
            // corrector, half folded into the shift
            5'd21: word = uop(SRC_K,    SRC_SX,   1'b1, AOP_ADD,  SRC_VX,    SRC_VX);
            5'd22: word = uop(SRC_K,    SRC_SY,   1'b1, AOP_SUB,  SRC_VY,    SRC_VY);
            A_CHK:  word = uctl(SEQ_DONE, '0, 1'b0, 1'b1);
            A_HOLD: word = uctl(SEQ_DONE, '0, 1'b0, 1'b0);
            A_LOAD: word = uctl(SEQ_DONE, '0, 1'b1, 1'b0);
            5'd4, 5'd5, 5'd11, 5'd14, 5'd16, 5'd17, 5'd20, 5'd23, 5'd24:
                   word = UC_NOP;
            default: word = uctl(SEQ_DONE, '0, 1'b0, 1'b0);
        endcase
    end

endmodule

@@ rtl/cpfs_datapath.sv @@
// ----------------------------------------------------------------------------
// cpfs_datapath - shared multiplier, rounding and saturating adder
// Three stages: multiply, round/saturate, add/subtract and write back.
// Holds particle state and the step temporaries.
// ----------------------------------------------------------------------------
module cpfs_datapath
    import cpfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  ucode_t uc,
    input  logic   issue,
    input  req_t   ld_item,
    output rsp_t   state,
    output logic   halted
);

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic               halted_reg;
    logic signed [31:0] k_reg, f0_reg, g_reg, sa_reg, sb_reg;
    logic signed [31:0] vxr_reg, vyr_reg, f1_reg, sx_reg, sy_reg;

    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] mres_reg, mres_next;
    logic signed [31:0] wb_next;
    logic signed [31:0] a_val, b_val, c_val;
    wbctl_t             s1_reg, s2_reg;
    logic               oob;

    function automatic logic signed [31:0] pick(input src_t s);
        case (s)
            SRC_DT:    return {1'b0, cfg.dt};
            SRC_QM:    return cfg.qm;
            SRC_ALPHA: return cfg.alpha;
            SRC_BETA:  return cfg.beta;
            SRC_PX:    return px_reg;
            SRC_PY:    return py_reg;
            SRC_VX:    return vx_reg;
            SRC_VY:    return vy_reg;
            SRC_K:     return k_reg;
            SRC_F0:    return f0_reg;
            SRC_G:     return g_reg;
            SRC_SA:    return sa_reg;
            SRC_SB:    return sb_reg;
            SRC_VXR:   return vxr_reg;
            SRC_VYR:   return vyr_reg;
            SRC_F1:    return f1_reg;
            SRC_SX:    return sx_reg;
            SRC_SY:    return sy_reg;
            default:   return 32'sd0;
        endcase
    endfunction

    always_comb
    begin
        a_val = pick(uc.a);
        b_val = pick(uc.b);
        c_val = pick(s2_reg.c);
    end

    assign prod_next = a_val * b_val;
    assign mres_next = round_sat(prod_reg, s1_reg.sh17);

    always_comb
    begin
        case (s2_reg.aop)
            AOP_ADD: wb_next = addsub_sat(c_val, mres_reg, 1'b0);
            AOP_SUB: wb_next = addsub_sat(c_val, mres_reg, 1'b1);
            default: wb_next = mres_reg;
        endcase
    end

    // below zero shows as the sign bit; above the limit only when non-negative
    assign oob = px_reg[31] | py_reg[31] | (px_reg[30:0] > cfg.box) |
                 (py_reg[30:0] > cfg.box);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg.wb   <= issue & uc.wb;
            s1_reg.dst  <= uc.dst;
            s1_reg.aop  <= uc.aop;
            s1_reg.c    <= uc.c;
            s1_reg.sh17 <= uc.sh17;
            s2_reg      <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mres_reg <= mres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg     <= '0;
            py_reg     <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            if (s2_reg.wb)
            begin
                case (s2_reg.dst)
                    SRC_PX:  px_reg <= wb_next;
                    SRC_PY:  py_reg <= wb_next;
                    SRC_VX:  vx_reg <= wb_next;
                    SRC_VY:  vy_reg <= wb_next;
                    default: ;
                endcase
            end
            if (issue && uc.ld)
            begin
                px_reg     <= ld_item.load_x;
                py_reg     <= ld_item.load_y;
                vx_reg     <= ld_item.load_vx;
                vy_reg     <= ld_item.load_vy;
                halted_reg <= 1'b0;
            end
            if (issue && uc.chk)
                halted_reg <= halted_reg | oob;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_reg.wb)
        begin
            case (s2_reg.dst)
                SRC_K:   k_reg   <= wb_next;
                SRC_F0:  f0_reg  <= wb_next;
                SRC_G:   g_reg   <= wb_next;
                SRC_SA:  sa_reg  <= wb_next;
                SRC_SB:  sb_reg  <= wb_next;
                SRC_VXR: vxr_reg <= wb_next;
                SRC_VYR: vyr_reg <= wb_next;
                SRC_F1:  f1_reg  <= wb_next;
                SRC_SX:  sx_reg  <= wb_next;
                SRC_SY:  sy_reg  <= wb_next;
                default: ;
            endcase
        end
    end

    assign state.pos_x_out     = px_reg;
    assign state.pos_y_out     = py_reg;
    assign state.vel_x_out     = vx_reg;
    assign state.vel_y_out     = vy_reg;
    assign state.out_of_bounds = halted_reg;
    assign halted              = halted_reg;

endmodule

@@ rtl/charged_particle_field_step_core.sv @@
// ----------------------------------------------------------------------------
// charged_particle_field_step_core - Heun step of a charged particle in B(x)
// An advance item runs the microprogram on one shared three-stage multiplier;
// a load item branches to the load word, a halted advance to the hold word.
// A new item is taken the cycle after the result is registered.
// Reset (async, active low) zeroes the state and restores default config.
// ----------------------------------------------------------------------------
module charged_particle_field_step_core
    import cpfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUB
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_inc;
    req_t              req_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    cfg_t              cfg_reg;

    ucode_t            uc;
    rsp_t              dp_state;
    logic              dp_halted;
    logic              run;

    assign run       = (state_reg == ST_RUN);
    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign step_inc  = step_reg + 5'd1;

    cpfs_ucode_rom u_rom (
        .addr (step_reg),
        .word (uc)
    );

    cpfs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .uc      (uc),
        .issue   (run),
        .ld_item (req_reg),
        .state   (dp_state),
        .halted  (dp_halted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qm    <= 32'sd65536;
            cfg_reg.alpha <= 32'sd0;
            cfg_reg.beta  <= 32'sd0;
            cfg_reg.dt    <= 31'd655;
            cfg_reg.box   <= 31'd39321600;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QM:    cfg_reg.qm    <= cfg_data;
                CFG_ALPHA: cfg_reg.alpha <= cfg_data;
                CFG_BETA:  cfg_reg.beta  <= cfg_data;
                CFG_DT:    cfg_reg.dt    <= cfg_data[30:0];
                CFG_BOX:   cfg_reg.box   <= cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // publish state reloads the output register itself
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_PUB)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    case (uc.seq)
                        SEQ_BR_LOAD: step_reg <= req_reg.cmd ? uc.target : step_inc;
                        SEQ_BR_HALT: step_reg <= dp_halted ? uc.target : step_inc;
                        SEQ_DONE:    state_reg <= ST_PUB;
                        default:     step_reg <= step_inc;
                    endcase
                end
                ST_PUB:
                begin
                    // output register free or draining this cycle
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= dp_state;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
